/* design/tls_hello_segment_splitter_assert.svh */
// assertion macros for the hello splitter
`ifndef TLS_HELLO_SEGMENT_SPLITTER_ASSERT_SVH
`define TLS_HELLO_SEGMENT_SPLITTER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define THS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define THS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/ths_pkg.sv */
// ----------------------------------------------------------------------------
// ths_pkg
// shared types and constants of the hello segment splitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ths_pkg;
  localparam logic [7:0]  TlsHandshake   = 8'h16;
  localparam logic [7:0]  TlsClientHello = 8'h01;
  localparam logic [15:0] IdStart        = 16'd10000;
  localparam logic [15:0] MinPacket      = 16'd40;
  localparam logic [7:0]  TcpProtocol    = 8'd6;
  localparam logic [31:0] AddrSplit      = 32'h0;

  // packet summary handed from the parser to the builder
  typedef struct packed {
    logic        do_split;
    logic [15:0] pay_len;
    logic [9:0]  split;
    logic [5:0]  ihl;
    logic [5:0]  thl;
    logic [19:0] addr_sum;
    logic [20:0] ip_sum;
    logic [21:0] tcp_sum;
    logic [31:0] seq;
    logic [31:0] head_sum;
    logic [31:0] tail_sum;
  } summary_t;

  typedef struct packed {
    logic        verdict;
    logic [15:0] t_len;
    logic [15:0] t_id;
    logic [31:0] t_seq;
    logic [15:0] t_ipc;
    logic [15:0] t_tcpc;
    logic [15:0] h_len;
    logic [15:0] h_id;
    logic [31:0] h_seq;
    logic [15:0] h_ipc;
    logic [15:0] h_tcpc;
  } result_t;

  // fold a sum up to 32 bits into 16 bits and complement
  function automatic logic [15:0] fold(input logic [31:0] x);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    b = {16'd0, a[16]} + {1'b0, a[15:0]};
    return ~(b[15:0] + {15'd0, b[16]});
  endfunction
endpackage

/* design/ths_parser.sv */
// ----------------------------------------------------------------------------
// ths_parser
// byte parser: header fields, partial sums and the split decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ths_parser #(
  parameter int MaxPacketBytes = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [9:0]          split_i,
  output logic                sum_valid_o,
  output ths_pkg::summary_t   sum_o
);
  logic [15:0] cnt_q;
  logic [5:0]  ihl_q, thl_q;
  logic [7:0]  proto_q;
  logic [19:0] addr_q;
  logic [20:0] ips_q;
  logic [21:0] tcps_q;
  logic [31:0] seq_q;
  logic [31:0] hs_q, ts_q;
  logic [1:0]  marks_q;

  logic [15:0] cnt_d;
  logic [5:0]  ihl_d, thl_d;
  logic [7:0]  proto_d;
  logic [19:0] addr_d;
  logic [20:0] ips_d;
  logic [21:0] tcps_d;
  logic [31:0] seq_d;
  logic [31:0] hs_d, ts_d;
  logic [1:0]  marks_d;
  logic [9:0]  split;
  logic [15:0] t, p, pm, wi, wt, wp, wq, hdrs;

  assign split = (split_i == 10'd0) ? 10'd1 : split_i;

  always_comb begin
    cnt_d = cnt_q; ihl_d = ihl_q; thl_d = thl_q; proto_d = proto_q;
    addr_d = addr_q; ips_d = ips_q; tcps_d = tcps_q; seq_d = seq_q;
    hs_d = hs_q; ts_d = ts_q; marks_d = marks_q;
    t  = cnt_q - {10'd0, ihl_q};
    p  = t - {10'd0, thl_q};
    pm = p - {6'd0, split};
    wi = cnt_q[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    wt = t[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    wp = p[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    wq = pm[0] ? {8'd0, byte_i} : {byte_i, 8'd0};
    if (cnt_q < 16'(MaxPacketBytes)) begin
      if (cnt_q == 16'd0) ihl_d = {byte_i[3:0], 2'b00};
      if (cnt_q == 16'd9) proto_d = byte_i;
      if (cnt_q < {10'd0, ihl_d}) begin
        if (!(cnt_q >= 16'd2 && cnt_q <= 16'd5) && cnt_q != 16'd10 && cnt_q != 16'd11)
          ips_d = ips_q + {5'd0, wi};
        if (cnt_q >= 16'd12 && cnt_q < 16'd20) addr_d = addr_q + {4'd0, wi};
      end else begin
        if (t == 16'd12) thl_d = {byte_i[7:4], 2'b00};
        if (t <= 16'd12 || t < {10'd0, thl_d}) begin
          if (t >= 16'd4 && t < 16'd8) seq_d = {seq_q[23:0], byte_i};
          else if (t != 16'd16 && t != 16'd17) tcps_d = tcps_q + {6'd0, wt};
        end else begin
          if (p == 16'd0 && byte_i == ths_pkg::TlsHandshake) marks_d[0] = 1'b1;
          if (p == 16'd5 && byte_i == ths_pkg::TlsClientHello) marks_d[1] = 1'b1;
          if (p < {6'd0, split}) hs_d = hs_q + {16'd0, wp};
          else ts_d = ts_q + {16'd0, wq};
        end
      end
      cnt_d = cnt_q + 16'd1;
    end
    hdrs = {10'd0, ihl_d} + {10'd0, thl_d};
    sum_o.do_split = cnt_d >= ths_pkg::MinPacket && proto_d == ths_pkg::TcpProtocol
      && ihl_d >= 6'd20 && thl_d >= 6'd20 && cnt_d > hdrs
      && (cnt_d - hdrs) >= 16'd6 && marks_d == 2'b11
      && (cnt_d - hdrs) > {6'd0, split};
    sum_o.pay_len  = cnt_d - hdrs;
    sum_o.split    = split;
    sum_o.ihl      = ihl_d;
    sum_o.thl      = thl_d;
    sum_o.addr_sum = addr_d;
    sum_o.ip_sum   = ips_d;
    sum_o.tcp_sum  = tcps_d;
    sum_o.seq      = seq_d;
    sum_o.head_sum = hs_d;
    sum_o.tail_sum = ts_d;
  end

  assign sum_valid_o = valid_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ihl_q <= '0; thl_q <= '0; proto_q <= '0; addr_q <= '0;
      ips_q <= '0; tcps_q <= '0; seq_q <= '0; hs_q <= '0; ts_q <= '0; marks_q <= '0;
    end else if (valid_i) begin
      if (last_i) begin
        cnt_q <= '0; ihl_q <= '0; thl_q <= '0; proto_q <= '0; addr_q <= '0;
        ips_q <= '0; tcps_q <= '0; seq_q <= '0; hs_q <= '0; ts_q <= '0;
        marks_q <= '0;
      end else begin
        cnt_q <= cnt_d; ihl_q <= ihl_d; thl_q <= thl_d; proto_q <= proto_d;
        addr_q <= addr_d; ips_q <= ips_d; tcps_q <= tcps_d; seq_q <= seq_d;
        hs_q <= hs_d; ts_q <= ts_d; marks_q <= marks_d;
      end
    end
  end
endmodule

/* design/ths_queue.sv */
// ----------------------------------------------------------------------------
// ths_queue
// two entry queue of packet summaries between parser and builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ths_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ths_pkg::summary_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output ths_pkg::summary_t data_o
);
  ths_pkg::summary_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

/* design/ths_builder.sv */
// ----------------------------------------------------------------------------
// ths_builder
// builds the segment descriptor: lengths, ids, sequences, checksums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ths_builder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ths_pkg::summary_t sum_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ths_pkg::result_t  res_o
);
  logic [15:0] id_q;
  logic        v_q;
  ths_pkg::result_t res_q, res_d;
  logic [15:0] tl_len, hl_len, t_tot, h_tot, id1;
  logic [31:0] t_seq;
  logic [31:0] tip, hip, ttc, htc;
  logic        take;

  assign ready_o = !v_q || ready_i;
  assign take = valid_i && ready_o;

  always_comb begin
    tl_len = {10'd0, sum_i.thl} + sum_i.pay_len - {6'd0, sum_i.split};
    hl_len = {10'd0, sum_i.thl} + {6'd0, sum_i.split};
    t_tot  = tl_len + {10'd0, sum_i.ihl};
    h_tot  = hl_len + {10'd0, sum_i.ihl};
    id1    = id_q + 16'd1;
    t_seq  = sum_i.seq + {22'd0, sum_i.split};
    tip = {11'd0, sum_i.ip_sum} + {16'd0, t_tot} + {16'd0, id_q};
    hip = {11'd0, sum_i.ip_sum} + {16'd0, h_tot} + {16'd0, id1};
    ttc = {12'd0, sum_i.addr_sum} + 32'(ths_pkg::TcpProtocol) + {16'd0, tl_len}
        + {10'd0, sum_i.tcp_sum} + {16'd0, t_seq[31:16]} + {16'd0, t_seq[15:0]}
        + sum_i.tail_sum;
    htc = {12'd0, sum_i.addr_sum} + 32'(ths_pkg::TcpProtocol) + {16'd0, hl_len}
        + {10'd0, sum_i.tcp_sum} + {16'd0, sum_i.seq[31:16]}
        + {16'd0, sum_i.seq[15:0]} + sum_i.head_sum;
    res_d = '0;
    if (sum_i.do_split) begin
      res_d.verdict = 1'b1;
      res_d.t_len = t_tot; res_d.t_id = id_q; res_d.t_seq = t_seq;
      res_d.t_ipc = ths_pkg::fold(tip); res_d.t_tcpc = ths_pkg::fold(ttc);
      res_d.h_len = h_tot; res_d.h_id = id1; res_d.h_seq = sum_i.seq;
      res_d.h_ipc = ths_pkg::fold(hip); res_d.h_tcpc = ths_pkg::fold(htc);
    end
  end

  assign valid_o = v_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0; id_q <= ths_pkg::IdStart;
    end else begin
      if (take) v_q <= 1'b1;
      else if (ready_i) v_q <= 1'b0;
      if (take && sum_i.do_split) id_q <= id_q + 16'd2;
    end
  end
endmodule

/* design/tls_hello_segment_splitter.sv */
// ----------------------------------------------------------------------------
// tls_hello_segment_splitter
// splits tcp packets carrying a tls client hello into two segments
// ----------------------------------------------------------------------------
// Packet bytes arrive on the s_axis channel, one per transfer, starting at the
// IPv4 header; tlast marks the final byte. One descriptor per packet leaves
// on m_axis after that byte: verdict 0 passes the packet, 1 gives tail and
// head segment headers with fresh ids, sequences and checksums.
// Throughput: one byte per cycle while the summary queue is not full; the
// parser sums each byte in one add. The descriptor passes the two entry
// summary queue and then the output register before it becomes valid.
// When the receiver stalls, descriptors fill the output register and queue;
// s_axis_tready drops only when the queue is full, so bytes keep flowing
// until two more packets end behind a stalled descriptor.
// split_position is written over the APB port at address 0; the user must
// write it only while idle, as the block does not enforce this. Reset clears
// all packet state, sets split_position to 1 and the ip id counter to 10000.
`timescale 1ns / 1ps
`include "tls_hello_segment_splitter_assert.svh"
module tls_hello_segment_splitter #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tail_total_length, tail_ip_id, tail_sequence, tail_ip_checksum,
  // tail_tcp_checksum, head_total_length, head_ip_id, head_sequence,
  // head_ip_checksum, head_tcp_checksum
  output logic [191:0] m_axis_tdata,
  output logic         m_axis_tuser,   // verdict
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  logic [9:0] split_q;
  logic acc, sv, qfull, qvalid, bready;
  ths_pkg::summary_t ps, qs;
  ths_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == ths_pkg::AddrSplit[1:0]) ? {22'd0, split_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) split_q <= 10'd1;
    else if (psel && penable && pwrite && paddr == ths_pkg::AddrSplit[1:0])
      split_q <= pwdata[9:0];
  end

  assign s_axis_tready = !qfull;
  assign acc = s_axis_tvalid && s_axis_tready;

  ths_parser #(.MaxPacketBytes(MAX_PACKET_BYTES)) u_parser (
    .clk_i, .rst_ni, .valid_i(acc), .byte_i(s_axis_tdata), .last_i(s_axis_tlast),
    .split_i(split_q), .sum_valid_o(sv), .sum_o(ps)
  );

  ths_queue u_queue (
    .clk_i, .rst_ni, .push_i(sv), .data_i(ps), .full_o(qfull),
    .valid_o(qvalid), .pop_i(qvalid && bready), .data_o(qs)
  );

  ths_builder u_builder (
    .clk_i, .rst_ni, .valid_i(qvalid), .sum_i(qs), .ready_o(bready),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tuser = res.verdict;
  assign m_axis_tdata = {res.h_tcpc, res.h_ipc, res.h_seq, res.h_id, res.h_len,
                         res.t_tcpc, res.t_ipc, res.t_seq, res.t_id, res.t_len};

  `THS_ASSERT_IMPL(a_accept_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata == 192'd0)
  `THS_ASSERT_IMPL(a_head_id, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    res.h_id == res.t_id + 16'd1)
  `THS_ASSERT_NEXT(a_last_out, clk_i, rst_ni, acc && s_axis_tlast && !qvalid
    && !m_axis_tvalid, 1'b1 ##1 m_axis_tvalid)
endmodule
